// ===== design/btx_pkg.sv =====
// ----------------------------------------------------------------------------
// btx_pkg
// shared constants, codes and control types of the max-xor trie unit
// ----------------------------------------------------------------------------
`default_nettype none

package btx_pkg;

  localparam int KEY_BITS  = 30;
  localparam int VALUE_W   = 30;
  localparam int NODE_POOL = 4096;
  localparam int CNT_W     = 20;
  localparam int NODE_W    = $clog2(NODE_POOL);
  localparam int FREE_W    = $clog2(NODE_POOL + 1);
  localparam int LVL_W     = $clog2(KEY_BITS);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_POOL_FULL   = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;

  // one trie node: both child links and the counts of both children
  typedef struct packed {
    logic [1:0][NODE_W-1:0] link;
    logic [1:0][CNT_W-1:0]  cnt;
  } node_t;

  typedef struct packed {
    logic             load;
    logic             init_wr;
    logic             rd;
    logic             chk_adv;
    logic             upd;
    logic             upd_dec;
    logic             qry;
    logic             restart;
    logic             finish;
    logic [1:0]       st;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic link_zero;
    logic cnt_max;
    logic cnt_zero;
    logic pool_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/btx_if.sv =====
// ----------------------------------------------------------------------------
// btx_if
// valid/ready channels for operation items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface btx_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [btx_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface btx_out_if;
  logic                       valid;
  logic                       ready;
  logic [btx_pkg::VALUE_W-1:0] max_xor;
  logic [1:0]                 status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink (input valid, input max_xor, input status, output ready);
endinterface

`default_nettype wire

// ===== design/btx_ctrl.sv =====
// ----------------------------------------------------------------------------
// btx_ctrl
// sequencer: init sweep, checking walk, updating walk, query walk, result
// ----------------------------------------------------------------------------
`default_nettype none

module btx_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_func,
  output logic               in_ready,
  input  wire btx_pkg::sts_t sts,
  output btx_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK_RD = 4'd2;
  localparam logic [3:0] S_CHK_EX = 4'd3;
  localparam logic [3:0] S_UPD_RD = 4'd4;
  localparam logic [3:0] S_UPD_EX = 4'd5;
  localparam logic [3:0] S_QRY_RD = 4'd6;
  localparam logic [3:0] S_QRY_EX = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  localparam logic [btx_pkg::LVL_W-1:0] LVL_TOP = btx_pkg::LVL_W'(btx_pkg::KEY_BITS - 1);

  logic [3:0]                state_r, state_nxt;
  logic [btx_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [1:0]                op_r, op_nxt;
  logic [1:0]                st_r, st_nxt;
  logic                      last_lvl;
  logic                      is_ins;

  assign last_lvl = (lvl_r == '0);
  assign is_ins   = (op_r == btx_pkg::FN_INSERT);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.lvl   = lvl_r;
    cmd.st    = st_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          op_nxt   = in_func;
          lvl_nxt  = LVL_TOP;
          st_nxt   = btx_pkg::ST_OK;
          unique case (in_func)
            btx_pkg::FN_INSERT, btx_pkg::FN_REMOVE: state_nxt = S_CHK_RD;
            btx_pkg::FN_QUERY:                      state_nxt = S_QRY_RD;
            default:                                state_nxt = S_FIN;
          endcase
        end
      end
      S_CHK_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK_EX;
      end
      S_CHK_EX: begin
        priority if (is_ins && sts.link_zero) begin
          // first missing link: the rest of the path is new
          if (sts.pool_ok) begin
            cmd.restart = 1'b1;
            lvl_nxt     = LVL_TOP;
            state_nxt   = S_UPD_RD;
          end else begin
            st_nxt    = btx_pkg::ST_POOL_FULL;
            state_nxt = S_FIN;
          end
        end else if (is_ins && sts.cnt_max) begin
          st_nxt    = btx_pkg::ST_POOL_FULL;
          state_nxt = S_FIN;
        end else if (!is_ins && (sts.link_zero || (last_lvl && sts.cnt_zero))) begin
          st_nxt    = btx_pkg::ST_NOT_PRESENT;
          state_nxt = S_FIN;
        end else if (last_lvl) begin
          cmd.restart = 1'b1;
          lvl_nxt     = LVL_TOP;
          state_nxt   = S_UPD_RD;
        end else begin
          cmd.chk_adv = 1'b1;
          lvl_nxt     = lvl_r - 1'b1;
          state_nxt   = S_CHK_RD;
        end
      end
      S_UPD_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD_EX;
      end
      S_UPD_EX: begin
        cmd.upd     = 1'b1;
        cmd.upd_dec = !is_ins;
        if (last_lvl) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_UPD_RD;
        end
      end
      S_QRY_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_QRY_EX;
      end
      S_QRY_EX: begin
        cmd.qry = 1'b1;
        if (last_lvl) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_QRY_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    st_r <= st_nxt;
  end

endmodule

`default_nettype wire

// ===== design/btx_dpath.sv =====
// ----------------------------------------------------------------------------
// btx_dpath
// node memory, walk pointer, node allocator and result register
// ----------------------------------------------------------------------------
`default_nettype none

module btx_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire btx_pkg::cmd_t               cmd,
  output btx_pkg::sts_t                    sts,
  input  wire logic [btx_pkg::VALUE_W-1:0] in_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [btx_pkg::VALUE_W-1:0]      out_max_xor,
  output logic [1:0]                       out_status
);

  localparam logic [btx_pkg::FREE_W:0]   POOL_LIM  = (btx_pkg::FREE_W + 1)'(btx_pkg::NODE_POOL);
  localparam logic [btx_pkg::FREE_W-1:0] FREE_INIT = btx_pkg::FREE_W'(btx_pkg::KEY_BITS + 1);

  btx_pkg::node_t mem [btx_pkg::NODE_POOL];
  btx_pkg::node_t rd_data_r;
  btx_pkg::node_t d;
  btx_pkg::node_t upd_w;
  btx_pkg::node_t init_w;
  btx_pkg::node_t wr_data;

  logic [btx_pkg::KEY_BITS-1:0] value_r;
  logic [btx_pkg::KEY_BITS-1:0] res_r;
  logic [btx_pkg::NODE_W-1:0]   cur_r;
  logic [btx_pkg::NODE_W-1:0]   wr_addr;
  logic [btx_pkg::FREE_W-1:0]   free_r;
  logic [btx_pkg::FREE_W:0]     need_sum;
  logic                         fresh_r;
  logic                         out_valid_r;
  logic [btx_pkg::VALUE_W-1:0]  out_max_xor_r;
  logic [1:0]                   out_status_r;
  logic                         b;
  logic                         take;
  logic                         alloc;
  logic                         wr_en;

  // a node allocated during this walk has not been written yet: it reads as empty
  assign d = fresh_r ? '0 : rd_data_r;
  assign b = value_r[cmd.lvl];

  assign take = (d.link[!b] != '0) && (d.cnt[!b] != '0);

  assign need_sum = (btx_pkg::FREE_W + 1)'(free_r) + (btx_pkg::FREE_W + 1)'(cmd.lvl)
                    + (btx_pkg::FREE_W + 1)'(1);

  assign sts.link_zero = (d.link[b] == '0);
  assign sts.cnt_max   = (d.cnt[b] == btx_pkg::COUNT_MAX);
  assign sts.cnt_zero  = (d.cnt[b] == '0);
  assign sts.pool_ok   = (need_sum <= POOL_LIM);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    upd_w = d;
    alloc = 1'b0;
    if (cmd.upd_dec) begin
      upd_w.cnt[b] = d.cnt[b] - 1'b1;
    end else begin
      alloc = (d.link[b] == '0);
      if (alloc) begin
        upd_w.link[b] = free_r[btx_pkg::NODE_W-1:0];
      end
      upd_w.cnt[b] = d.cnt[b] + 1'b1;
    end
  end

  // reset image: the path of value zero, node n links to n+1 on the zero side
  always_comb begin
    init_w         = '0;
    init_w.link[0] = btx_pkg::NODE_W'(cmd.lvl) + 1'b1;
    init_w.cnt[0]  = btx_pkg::CNT_W'(1);
  end

  assign wr_en   = cmd.init_wr || cmd.upd;
  assign wr_addr = cmd.init_wr ? btx_pkg::NODE_W'(cmd.lvl) : cur_r;
  assign wr_data = cmd.init_wr ? init_w : upd_w;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value[btx_pkg::KEY_BITS-1:0];
      res_r   <= '0;
      cur_r   <= '0;
    end else if (cmd.restart) begin
      cur_r <= '0;
    end else if (cmd.chk_adv) begin
      cur_r <= d.link[b];
    end else if (cmd.upd) begin
      cur_r <= upd_w.link[b];
    end else if (cmd.qry) begin
      res_r[cmd.lvl] <= take;
      cur_r          <= take ? d.link[!b] : d.link[b];
    end
    if (cmd.finish) begin
      out_max_xor_r <= btx_pkg::VALUE_W'(res_r);
      out_status_r  <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= FREE_INIT;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.restart) begin
        fresh_r <= 1'b0;
      end else if (cmd.upd) begin
        fresh_r <= alloc;
      end
      if (cmd.upd && alloc) begin
        free_r <= free_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_max_xor = out_max_xor_r;
  assign out_status  = out_status_r;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= btx_pkg::FREE_W'(btx_pkg::NODE_POOL))
    else $error("node allocator ran past the pool");

  a_fresh_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && !cmd.upd_dec && fresh_r) |-> alloc)
    else $error("fresh node already has a child link");

  a_fresh_remove: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r |-> !(cmd.upd && cmd.upd_dec))
    else $error("remove walk reached an unwritten node");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && cmd.st != btx_pkg::ST_OK) |=> (out_max_xor_r == '0))
    else $error("rejected operation returned nonzero xor");
`endif

endmodule

`default_nettype wire

// ===== design/binary_trie_max_xor_multiset_unit.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset_unit
// multiset of 30-bit values in a bitwise trie with maximum-xor query
// ----------------------------------------------------------------------------
// Each operation item is insert, remove or query and yields exactly one result
// transfer (max_xor, status). The trie lives in a 4096-entry node memory; each
// entry holds both child links of a node and the counts of both children, so
// one memory read per level gives everything a walk needs. Every level takes
// an address state, then a registered read data state, so the node memory
// read port sets the rate: a query is one walk of 30 levels, an insert or
// remove a checking walk of up to 30 levels, then an updating walk of 30
// levels that writes each node back, and a rejected update ends early at the
// level where it fails. Results go out through an output register, so a new
// item is taken while the previous result still waits. After reset a clearing
// pass writes the path of value zero into the node memory (the set then
// holds the single value 0); no item is taken during it. Nodes are never
// freed: an insert that needs more new nodes than the pool has left, or that
// would push a count past its 20-bit maximum, is rejected with status
// pool_full; a remove of an absent value is rejected with status not_present.
// Function code 3 does nothing and answers zero with status ok.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_max_xor_multiset_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  btx_in_if.sink     in_ch,
  btx_out_if.source  out_ch
);

  // command and status bundles between sequencer and datapath
  btx_pkg::cmd_t cmd;
  btx_pkg::sts_t sts;

  // sequencer: owns the input handshake and the level counter
  btx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: node memory, walk pointer, allocator and output register
  btx_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_max_xor (out_ch.max_xor),
    .out_status  (out_ch.status)
  );

endmodule

`default_nettype wire

// ===== tb/btx_result_checker.sv =====
// ----------------------------------------------------------------------------
// btx_result_checker
// predicts each result of the max-xor trie unit and compares it on transfer
// ----------------------------------------------------------------------------
// Keeps its own copy of the trie: child links, path counts and the free-node
// pointer. Every accepted operation is applied to that copy, and the outcome is
// queued. Each result transfer is then compared, field by field, with the
// oldest entry in the queue.
// ----------------------------------------------------------------------------
module btx_result_checker
  import btx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  btx_in_if    in_ch,
  btx_out_if   out_ch,
  output int   error_count,
  output int   results_owed
);

  typedef struct packed {
    logic [VALUE_W-1:0] max_xor;
    logic [1:0]         status;
  } op_result_t;

  // shadow trie
  logic [NODE_W-1:0] child_link [NODE_POOL][2];
  logic [CNT_W-1:0]  path_count [NODE_POOL];
  logic [FREE_W-1:0] free_node;

  op_result_t owed_results [$];

  task automatic report_mismatch(string what);
    if (error_count < 40) $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // empty pool plus the path of value zero
  function automatic void trie_clear();
    for (int n = 0; n < NODE_POOL; n++) begin
      child_link[n][0] = '0;
      child_link[n][1] = '0;
      path_count[n]    = '0;
    end
    for (int n = 0; n < KEY_BITS; n++) begin
      child_link[n][0] = NODE_W'(n + 1);
      path_count[n+1]  = CNT_W'(1);
    end
    free_node = FREE_W'(KEY_BITS + 1);
  endfunction

  function automatic logic [1:0] trie_insert(logic [VALUE_W-1:0] v);
    int unsigned cur;
    int unsigned nxt;
    int unsigned needed;
    cur    = 0;
    needed = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      nxt = child_link[cur][v[lvl]];
      if (nxt == 0) begin
        needed = lvl + 1;
        break;
      end
      if (path_count[nxt] == COUNT_MAX) return ST_POOL_FULL;
      cur = nxt;
    end
    if (int'(free_node) + needed > NODE_POOL) return ST_POOL_FULL;
    cur = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (child_link[cur][v[lvl]] == '0) begin
        child_link[free_node][0] = '0;
        child_link[free_node][1] = '0;
        path_count[free_node]    = '0;
        child_link[cur][v[lvl]]  = NODE_W'(free_node);
        free_node++;
      end
      cur = child_link[cur][v[lvl]];
      path_count[cur]++;
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] trie_remove(logic [VALUE_W-1:0] v);
    int unsigned cur;
    cur = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      cur = child_link[cur][v[lvl]];
      if (cur == 0) return ST_NOT_PRESENT;
    end
    if (path_count[cur] == '0) return ST_NOT_PRESENT;
    cur = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      cur = child_link[cur][v[lvl]];
      path_count[cur]--;
    end
    return ST_OK;
  endfunction

  // greedy walk: take the opposite bit wherever that subtree is populated
  function automatic logic [VALUE_W-1:0] trie_best_xor(logic [VALUE_W-1:0] key);
    int unsigned        cur;
    int unsigned        opp;
    logic [VALUE_W-1:0] best;
    cur  = 0;
    best = '0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      opp = child_link[cur][~key[lvl]];
      if (opp != 0 && path_count[opp] != '0) begin
        best[lvl] = 1'b1;
        cur       = opp;
      end else begin
        cur = child_link[cur][key[lvl]];
      end
    end
    return best;
  endfunction

  function automatic op_result_t apply_op(logic [1:0] fn, logic [VALUE_W-1:0] v);
    op_result_t r;
    r = '0;
    case (fn)
      FN_INSERT: r.status  = trie_insert(v);
      FN_REMOVE: r.status  = trie_remove(v);
      FN_QUERY:  r.max_xor = trie_best_xor(v);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    op_result_t want;
    if (!rst_n) begin
      trie_clear();
      owed_results.delete();
      error_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing owed (max_xor %h status %0d)",
                                    out_ch.max_xor, out_ch.status));
        end else begin
          want = owed_results.pop_front();
          if (out_ch.max_xor !== want.max_xor)
            report_mismatch($sformatf("max_xor got %h want %h", out_ch.max_xor, want.max_xor));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        owed_results.insert(owed_results.size(), apply_op(in_ch.func, in_ch.value));
    end
    results_owed <= owed_results.size();
  end

endmodule

// ===== tb/binary_trie_max_xor_multiset_unit_tb.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset_unit_tb
// stimulus and verdict for the max-xor trie unit
// ----------------------------------------------------------------------------
// A short directed sequence covers the boundary keys, every operation, removal
// of absent values, a query on an empty set and the unused function code.
// Random phases then mix inserts, removes of live values and queries, with one
// phase that pushes the node pool into exhaustion. Both channels idle at
// random, and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_multiset_unit_tb;
  import btx_pkg::*;

  // function code with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 300;
  // long result-side hold, counted in clock cycles
  localparam int HOLD_START   = 2000;
  localparam int HOLD_CYCLES  = 1000;

  // high parts shared by clustered values, so many inserts reuse trie paths
  localparam logic [19:0] FAMILY_HI [4] = '{20'h00000, 20'hFFFFF, 20'hA5A5A, 20'h3C3C3};

  logic clk;
  logic rst_n;
  int   error_count;
  int   results_owed;

  // values that have been inserted and not yet picked for removal
  logic [VALUE_W-1:0] live_values [$];

  btx_in_if  in_ch ();
  btx_out_if out_ch ();

  binary_trie_max_xor_multiset_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  btx_result_checker result_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [VALUE_W-1:0] family_value();
    return {FAMILY_HI[$urandom_range(0, 3)], 10'($urandom())};
  endfunction

  // offer one operation and hold it until the transfer; valid is only lowered
  // when a gap follows, so it never gets two assignments in one step
  task automatic send_op(logic [1:0] fn, logic [VALUE_W-1:0] v, bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= fn;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_directed();
    // set holds only zero after reset
    send_op(FN_QUERY,  30'h00000000, 1'b0);
    send_op(FN_QUERY,  30'h3FFFFFFF, 1'b0);
    send_op(FN_UNUSED, 30'h3FFFFFFF, 1'b0);
    send_op(FN_INSERT, 30'h3FFFFFFF, 1'b0);
    send_op(FN_QUERY,  30'h00000000, 1'b0);
    send_op(FN_QUERY,  30'h3FFFFFFF, 1'b0);
    // duplicate, then take both copies out
    send_op(FN_INSERT, 30'h3FFFFFFF, 1'b0);
    send_op(FN_REMOVE, 30'h3FFFFFFF, 1'b0);
    send_op(FN_QUERY,  30'h00000000, 1'b0);
    send_op(FN_REMOVE, 30'h3FFFFFFF, 1'b0);
    // path exists but leaf count is zero
    send_op(FN_REMOVE, 30'h3FFFFFFF, 1'b0);
    // path never built
    send_op(FN_REMOVE, 30'h15555555, 1'b0);
    // empty the set and query it
    send_op(FN_REMOVE, 30'h00000000, 1'b0);
    send_op(FN_QUERY,  30'h2AAAAAAA, 1'b0);
    send_op(FN_REMOVE, 30'h00000000, 1'b0);
    send_op(FN_INSERT, 30'h2AAAAAAA, 1'b0);
    send_op(FN_INSERT, 30'h15555555, 1'b0);
    send_op(FN_QUERY,  30'h00000000, 1'b0);
    send_op(FN_QUERY,  30'h3FFFFFFF, 1'b0);
    send_op(FN_INSERT, 30'h00000000, 1'b0);
    send_op(FN_UNUSED, 30'h00000000, 1'b0);
    send_op(FN_QUERY,  30'h20000000, 1'b0);
  endtask

  // fill_pool: mostly unrelated inserts, which eat fresh nodes fast
  task automatic run_random(int count, bit fill_pool);
    logic [1:0]         fn;
    logic [VALUE_W-1:0] v;
    int                 pick;
    int                 idx;
    bit                 calm;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      v    = VALUE_W'($urandom());
      calm = ((n / 32) % 4) == 2;
      if (fill_pool) begin
        fn = (pick < 80) ? FN_INSERT : FN_QUERY;
        if (fn == FN_INSERT) live_values.insert(live_values.size(), v);
      end else if (pick < 40) begin
        fn = FN_INSERT;
        case ($urandom_range(0, 3))
          0, 1: v = family_value();
          2: if (live_values.size() > 0)
               v = live_values[$urandom_range(0, live_values.size() - 1)];
          default: ;
        endcase
        live_values.insert(live_values.size(), v);
      end else if (pick < 65) begin
        fn = FN_REMOVE;
        if (live_values.size() > 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, live_values.size() - 1);
          v   = live_values[idx];
          live_values.delete(idx);
        end else if ($urandom_range(0, 1) == 0) begin
          v = family_value();
        end
      end else if (pick < 95) begin
        fn = FN_QUERY;
        if ($urandom_range(0, 1) == 0) v = family_value();
      end else begin
        fn = FN_UNUSED;
      end
      send_op(fn, v, calm);
    end
  endtask

  // operation side
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.func  <= FN_QUERY;
    in_ch.value <= '0;
    rst_n       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(150, 1'b0);
    run_random(150, 1'b1);
    run_random(200, 1'b0);
    in_ch.valid <= 1'b0;

    // drain, then let any stray result surface; the owed count is registered and is
    // read from the edge after the last transfer, so it already includes that item
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, calm stretches and one long hold
  initial begin
    int cycle_count;
    int stall_left;
    out_ch.ready <= 1'b0;
    cycle_count = 0;
    stall_left  = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (cycle_count == HOLD_START) begin
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && ((cycle_count / 1500) % 4) != 1 &&
                   $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      cycle_count++;
    end
  end

  // hang guard
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/btx_pkg.sv
design/btx_if.sv
design/btx_ctrl.sv
design/btx_dpath.sv
design/binary_trie_max_xor_multiset_unit.sv
tb/btx_result_checker.sv
tb/binary_trie_max_xor_multiset_unit_tb.sv
